// ===== rtl/core/mpq_pkg.sv =====
// Shared types and codes for the min priority queue.
// No dependencies; imported by min_priority_queue.
package mpq_pkg;

  localparam int ID_W  = 16;
  localparam int SEV_W = 8;
  localparam int OCC_W = 7;

  typedef enum logic {
    REQ_INSERT  = 1'b0,
    REQ_EXTRACT = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REMOVED  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // One heap entry as stored: id in the upper bits, severity in the lower.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SEV_W-1:0] sev;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    req_kind_t        req_type;
    logic [ID_W-1:0]  entry_id;
    logic [SEV_W-1:0] severity;
  } mpq_req_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  removed_id;
    logic [SEV_W-1:0] removed_severity;
    logic [OCC_W-1:0] occupancy;
  } mpq_rsp_t;

endpackage

// ===== rtl/core/mpq_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mpq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/min_priority_queue.sv =====
// Bounded min priority queue kept as a binary heap in one RAM (mpq_ram).
// Depends on mpq_pkg for word types and status codes.
//
// A request word is taken when start is high and busy is low. Exactly one
// response word follows. It is held on rsp for the single cycle that done is
// high, and the receiver must take it then, since it cannot stall. An insert to
// a full queue and an extract from an empty queue are answered from the idle
// state without a heap walk. An insert moves the new entry up level by level
// until it reaches the root or meets a parent that is not greater. An extract
// reads the root and the last entry; if that was the last entry it answers
// from the load state, else it moves the last entry down from the root until
// it reaches a leaf or no child is smaller. Each heap level has a read state
// that reads the heap RAM (registered read; going down, the two read ports
// serve the two children) and a compare state that compares and writes back.
// Busy stays high for that whole walk and drops in the cycle that done is
// high, so the next word can be taken at the edge that takes the response.
module min_priority_queue
  import mpq_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  mpq_req_t req,
  output logic     done,
  output mpq_rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_EX_LD,
    ST_DN_RD,
    ST_DN_CMP
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [AW-1:0]   idx;
  entry_t          moving;
  entry_t          top;

  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic [AW-1:0]   raddr_a;
  logic [AW-1:0]   raddr_b;
  entry_t          rda;
  entry_t          rdb;

  logic [AW-1:0]   parent;
  logic [IW-1:0]   left_i;
  logic [IW-1:0]   right_i;
  logic            at_leaf;
  logic            use_right;
  entry_t          child;
  logic [AW-1:0]   child_idx;
  logic            up_move;
  logic            dn_move;

  mpq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_heap (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .raddr_a(raddr_a),
    .rdata_a(rda),
    .raddr_b(raddr_b),
    .rdata_b(rdb)
  );

  assign busy      = (state != ST_IDLE);
  assign parent    = AW'((idx - AW'(1)) >> 1);
  assign left_i    = IW'({idx, 1'b1});
  assign right_i   = left_i + IW'(1);
  assign at_leaf   = (left_i >= IW'(count));
  // Left child wins on equal severity.
  assign use_right = (right_i < IW'(count)) && (rdb.sev < rda.sev);
  assign child     = use_right ? rdb : rda;
  assign child_idx = use_right ? right_i[AW-1:0] : left_i[AW-1:0];
  assign up_move   = (rda.sev > moving.sev);
  assign dn_move   = (child.sev < moving.sev);

  // RAM port control
  always_comb begin
    we      = 1'b0;
    waddr   = idx;
    wdata   = moving;
    raddr_a = '0;
    raddr_b = AW'(count - CW'(1));
    case (state)
      ST_UP_RD: begin
        raddr_a = parent;
        we      = (idx == '0);
      end
      ST_UP_CMP: begin
        we = 1'b1;
        if (up_move) begin
          wdata = rda;
        end
      end
      ST_DN_RD: begin
        raddr_a = left_i[AW-1:0];
        raddr_b = right_i[AW-1:0];
        we      = at_leaf;
      end
      ST_DN_CMP: begin
        we = 1'b1;
        if (dn_move) begin
          wdata = child;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            if (req.req_type == REQ_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                done <= 1'b1;
                rsp  <= '{status: STAT_FULL, removed_id: '0, removed_severity: '0,
                          occupancy: OCC_W'(count)};
              end else begin
                moving <= '{id: req.entry_id, sev: req.severity};
                idx    <= AW'(count);
                count  <= count + CW'(1);
                state  <= ST_UP_RD;
              end
            end else begin
              if (count == '0) begin
                done <= 1'b1;
                rsp  <= '{status: STAT_EMPTY, removed_id: '0, removed_severity: '0,
                          occupancy: '0};
              end else begin
                // root and last entry are being read now
                count <= count - CW'(1);
                state <= ST_EX_LD;
              end
            end
          end
        end
        ST_UP_RD: begin
          if (idx == '0) begin
            done  <= 1'b1;
            rsp   <= '{status: STAT_INSERTED, removed_id: '0, removed_severity: '0,
                       occupancy: OCC_W'(count)};
            state <= ST_IDLE;
          end else begin
            state <= ST_UP_CMP;
          end
        end
        ST_UP_CMP: begin
          if (up_move) begin
            idx   <= parent;
            state <= ST_UP_RD;
          end else begin
            done  <= 1'b1;
            rsp   <= '{status: STAT_INSERTED, removed_id: '0, removed_severity: '0,
                       occupancy: OCC_W'(count)};
            state <= ST_IDLE;
          end
        end
        ST_EX_LD: begin
          top    <= rda;
          moving <= rdb;
          idx    <= '0;
          if (count == '0) begin
            done  <= 1'b1;
            rsp   <= '{status: STAT_REMOVED, removed_id: rda.id,
                       removed_severity: rda.sev, occupancy: '0};
            state <= ST_IDLE;
          end else begin
            state <= ST_DN_RD;
          end
        end
        ST_DN_RD: begin
          if (at_leaf) begin
            done  <= 1'b1;
            rsp   <= '{status: STAT_REMOVED, removed_id: top.id,
                       removed_severity: top.sev, occupancy: OCC_W'(count)};
            state <= ST_IDLE;
          end else begin
            state <= ST_DN_CMP;
          end
        end
        ST_DN_CMP: begin
          if (dn_move) begin
            idx   <= child_idx;
            state <= ST_DN_RD;
          end else begin
            done  <= 1'b1;
            rsp   <= '{status: STAT_REMOVED, removed_id: top.id,
                       removed_severity: top.sev, occupancy: OCC_W'(count)};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == ST_IDLE))
    else $error("response word issued while walk still running");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted word neither answered nor in progress");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_REMOVED) |->
      (rsp.removed_id == '0 && rsp.removed_severity == '0))
    else $error("removed fields set on non-remove response");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (CW'(waddr) < count))
    else $error("heap write outside occupied entries");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for min_priority_queue: drives insert and extract words,
// predicts every response with a heap model of its own and compares field by field.
// Depends on mpq_pkg and min_priority_queue.
module testbench;
  import mpq_pkg::*;

  localparam int CAPACITY       = 64;
  localparam int LATENCY_CYCLES = 2 * 6 + 4;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  mpq_req_t req;
  logic     done;
  mpq_rsp_t rsp;

  entry_t      model_heap [CAPACITY];
  int unsigned model_count = 0;
  mpq_rsp_t    pending_rsp [$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left = 1;

  min_priority_queue #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (mismatch_count < 50) begin
      $display("ERROR at %0t: %s: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Apply one request word to the heap model and return the response it must produce.
  function automatic mpq_rsp_t serve_request(input mpq_req_t w);
    mpq_rsp_t    r;
    entry_t      moving;
    int unsigned idx;
    int unsigned parent;
    int unsigned child;
    bit          walking;
    r = '0;
    if (w.req_type == REQ_INSERT) begin
      if (model_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        moving.id  = w.entry_id;
        moving.sev = w.severity;
        idx        = model_count;
        walking    = 1'b1;
        // Move up only past strictly greater parents.
        while (walking && idx > 0) begin
          parent = (idx - 1) / 2;
          if (model_heap[parent].sev > moving.sev) begin
            model_heap[idx] = model_heap[parent];
            idx             = parent;
          end else begin
            walking = 1'b0;
          end
        end
        model_heap[idx] = moving;
        model_count++;
        r.status = STAT_INSERTED;
      end
    end else if (model_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.status           = STAT_REMOVED;
      r.removed_id       = model_heap[0].id;
      r.removed_severity = model_heap[0].sev;
      moving             = model_heap[model_count - 1];
      model_count--;
      if (model_count > 0) begin
        idx     = 0;
        walking = 1'b1;
        // Left child wins ties; move down only past a strictly smaller child.
        while (walking && 2 * idx + 1 < model_count) begin
          child = 2 * idx + 1;
          if (child + 1 < model_count && model_heap[child + 1].sev < model_heap[child].sev) begin
            child++;
          end
          if (model_heap[child].sev < moving.sev) begin
            model_heap[idx] = model_heap[child];
            idx             = child;
          end else begin
            walking = 1'b0;
          end
        end
        model_heap[idx] = moving;
      end
    end
    r.occupancy = OCC_W'(model_count);
    return r;
  endfunction

  // Check responses first: a word accepted at this edge cannot answer at the same edge.
  always @(posedge clk) begin : watch_ports
    mpq_rsp_t want;
    if (!rst) begin
      if (done) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("response with none pending", longint'(rsp), 0);
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status) begin
            report_mismatch("status", longint'(rsp.status), longint'(want.status));
          end
          if (rsp.removed_id !== want.removed_id) begin
            report_mismatch("removed_id", longint'(rsp.removed_id),
                            longint'(want.removed_id));
          end
          if (rsp.removed_severity !== want.removed_severity) begin
            report_mismatch("removed_severity", longint'(rsp.removed_severity),
                            longint'(want.removed_severity));
          end
          if (rsp.occupancy !== want.occupancy) begin
            report_mismatch("occupancy", longint'(rsp.occupancy),
                            longint'(want.occupancy));
          end
        end
      end
      if (start && !busy) begin
        pending_rsp = {pending_rsp, serve_request(req)};
      end
    end
  end

  // Called at a falling edge; returns at a falling edge once taken, after any gap.
  task automatic send_req(input req_kind_t kind, input logic [ID_W-1:0] id,
                          input logic [SEV_W-1:0] sev);
    mpq_req_t w;
    int       gap;
    w.req_type = kind;
    w.entry_id = id;
    w.severity = sev;
    start <= 1'b1;
    req   <= w;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
    end
  endtask

  // Mix tie-heavy low and high clusters with the full severity range.
  function automatic logic [SEV_W-1:0] pick_sev();
    case ($urandom_range(0, 3))
      0:       return SEV_W'($urandom_range(0, 3));
      1:       return SEV_W'(252 + $urandom_range(0, 3));
      default: return SEV_W'($urandom);
    endcase
  endfunction

  task automatic test_directed_cases();
    send_req(REQ_EXTRACT, 16'hFFFF, 8'hFF);
    send_req(REQ_INSERT, 16'h0000, 8'hFF);
    send_req(REQ_INSERT, 16'hFFFF, 8'h00);
    send_req(REQ_INSERT, 16'h1234, 8'h80);
    send_req(REQ_INSERT, 16'hAAAA, 8'h80);
    send_req(REQ_INSERT, 16'h5555, 8'h80);
    send_req(REQ_INSERT, 16'h0F0F, 8'h80);
    send_req(REQ_INSERT, 16'h00FF, 8'h00);
    send_req(REQ_INSERT, 16'hFF00, 8'hFF);
    repeat (8) send_req(REQ_EXTRACT, 16'h0000, 8'h00);
    send_req(REQ_EXTRACT, 16'h0000, 8'h00);
    send_req(REQ_INSERT, 16'h8001, 8'h7F);
    send_req(REQ_EXTRACT, 16'hFFFF, 8'hFF);
  endtask

  // Fill to capacity, push past full, drain past empty.
  task automatic test_fill_and_drain(input int rounds);
    repeat (rounds) begin
      while (model_count < CAPACITY) begin
        if ($urandom_range(0, 99) < 15) send_req(REQ_EXTRACT, ID_W'($urandom), SEV_W'($urandom));
        else send_req(REQ_INSERT, ID_W'($urandom), pick_sev());
      end
      repeat ($urandom_range(1, 4)) send_req(REQ_INSERT, ID_W'($urandom), pick_sev());
      while (model_count > 0) begin
        if ($urandom_range(0, 99) < 10) send_req(REQ_INSERT, ID_W'($urandom), pick_sev());
        else send_req(REQ_EXTRACT, ID_W'($urandom), SEV_W'($urandom));
      end
      repeat ($urandom_range(1, 3)) send_req(REQ_EXTRACT, ID_W'($urandom), SEV_W'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int count, input int insert_pct);
    repeat (count) begin
      if ($urandom_range(0, 99) < insert_pct) send_req(REQ_INSERT, ID_W'($urandom), pick_sev());
      else send_req(REQ_EXTRACT, ID_W'($urandom), SEV_W'($urandom));
    end
  endtask

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_cases();
    test_fill_and_drain(4);
    test_random_traffic(400, 50);
    test_random_traffic(400, 70);
    test_random_traffic(400, 30);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (LATENCY_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
